// ===== rtl/dlx_pkg.sv =====
// Shared constants, types and helpers for the DFA longest-match lexer.
package dlx_pkg;

	localparam int NUM_STATES = 64;
	localparam int ST_W       = $clog2(NUM_STATES);
	localparam int MAX_LEXEME = 32;
	localparam int LEN_W      = 6;
	localparam int TOKEN_BITS = 6;
	localparam int SYM_W      = 9;
	localparam int TBL_AW     = ST_W + SYM_W;
	localparam int TBL_W      = ST_W + 1;
	localparam int INFO_W     = TOKEN_BITS + 1;
	localparam int LB_AW      = $clog2(MAX_LEXEME) + 1;
	localparam int LB_DEPTH   = 1 << LB_AW;
	localparam int POS_W      = 32;

	localparam logic [ST_W-1:0] START_RESET = ST_W'(1);

	// input item kinds
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_TRANS = 2'd1;
	localparam logic [1:0] KIND_INFO  = 2'd2;

	// special bytes
	localparam logic [7:0] BYTE_BSLASH = 8'h5C;
	localparam logic [7:0] BYTE_SPACE  = 8'h20;
	localparam logic [7:0] BYTE_NL     = 8'h0A;
	localparam logic [7:0] BYTE_TAB    = 8'h09;

	// commands from the controller, one per controller state
	typedef struct packed {
		logic clear;
		logic idle;
		logic step;
		logic consume;
		logic look;
		logic info;
		logic flush;
		logic finish;
	} dlx_cmd_t;

	// status from the datapath
	typedef struct packed {
		logic clear_done;
		logic start;
		logic caught_up;
		logic run_full;
		logic need_look;
		logic tbl_hit;
		logic is_last;
		logic flush_ok;
		logic finish_ok;
	} dlx_sts_t;

	typedef struct packed {
		logic                  is_error;
		logic [TOKEN_BITS-1:0] token_id;
		logic [POS_W-1:0]      start_pos;
		logic [LEN_W-1:0]      lexeme_length;
	} dlx_res_t;

	// plain space, newline or tab; escaped symbols never count
	function automatic logic is_ws(input logic [SYM_W-1:0] sym);
		logic r;
		r = (sym == {1'b0, BYTE_SPACE}) || (sym == {1'b0, BYTE_NL}) ||
			(sym == {1'b0, BYTE_TAB});
		return r;
	endfunction

endpackage

// ===== rtl/dlx_if.sv =====
// Item and result channel interfaces of the lexer.
interface dlx_in_if;
	import dlx_pkg::*;
	logic            valid;
	logic            ready;
	logic [1:0]      kind;
	logic [7:0]      char_byte;
	logic            end_of_input;
	logic [ST_W-1:0] state_index;
	logic [SYM_W-1:0] symbol_code;
	logic [ST_W-1:0] target_state;
	logic            entry_valid;
	logic            accepting;
	logic [TOKEN_BITS-1:0] token_code;

	modport source (output valid, kind, char_byte, end_of_input, state_index, symbol_code,
		target_state, entry_valid, accepting, token_code, input ready);
	modport sink (input valid, kind, char_byte, end_of_input, state_index, symbol_code,
		target_state, entry_valid, accepting, token_code, output ready);
endinterface

interface dlx_out_if;
	import dlx_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  is_error;
	logic [TOKEN_BITS-1:0] token_id;
	logic [POS_W-1:0]      start_pos;
	logic [LEN_W-1:0]      lexeme_length;
	logic                  last;

	modport source (output valid, is_error, token_id, start_pos, lexeme_length, last,
		input ready);
	modport sink (input valid, is_error, token_id, start_pos, lexeme_length, last,
		output ready);
endinterface

// ===== rtl/dfa_longest_match_lexer_core.sv =====
// Top level of the DFA longest-match lexer: controller plus datapath.
//
// channel   dir  handshake      payload
// items     in   valid/ready    kind, char_byte, end_of_input, load fields
// results   out  valid/ready    is_error, token_id, start_pos, lexeme_length, last
// cfg       in   cfg_we         cfg_wdata = start_state
//
// Loads and characters are taken only while idle. Each byte scanned passes through
// step and read (buffer read); an escape prefix stops there, a dead transition adds a
// look (table read) and then a flush, any other byte a look and a state info read.
// After reset a clearing pass empties the transition table;
// no item is taken meanwhile. Rescans replay from the lookahead buffer
// while input stalls; a full result register stalls emitting flushes and the finish.
module dfa_longest_match_lexer_core
	import dlx_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [ST_W-1:0] cfg_wdata,
	dlx_in_if.sink          items,
	dlx_out_if.source       results
);

	dlx_cmd_t cmd;
	dlx_sts_t sts;

	dlx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	dlx_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.results   (results),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== rtl/dlx_ctrl.sv =====
// Controller state machine that sequences clearing, loads, scans and flushes.
module dlx_ctrl
	import dlx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dlx_sts_t sts,
	output dlx_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_STEP   = 8'b0000_0100,
		S_READ   = 8'b0000_1000,
		S_LOOK   = 8'b0001_0000,
		S_INFO   = 8'b0010_0000,
		S_FLUSH  = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// pick the next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (sts.clear_done) state_d = S_IDLE;
			S_IDLE:   if (sts.start) state_d = S_STEP;
			S_STEP: begin
				if (sts.caught_up) state_d = S_FINISH;
				else if (sts.run_full) state_d = S_FLUSH;
				else state_d = S_READ;
			end
			S_READ:   state_d = sts.need_look ? S_LOOK : S_STEP;
			S_LOOK:   state_d = sts.tbl_hit ? S_INFO : S_FLUSH;
			S_INFO:   state_d = sts.is_last ? S_FLUSH : S_STEP;
			S_FLUSH:  if (sts.flush_ok) state_d = S_STEP;
			S_FINISH: if (sts.finish_ok) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	// decode commands
	always_comb begin
		cmd.clear   = (state_q == S_CLEAR);
		cmd.idle    = (state_q == S_IDLE);
		cmd.step    = (state_q == S_STEP);
		cmd.consume = (state_q == S_READ);
		cmd.look    = (state_q == S_LOOK);
		cmd.info    = (state_q == S_INFO);
		cmd.flush   = (state_q == S_FLUSH);
		cmd.finish  = (state_q == S_FINISH);
	end

	ast_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(cmd))
		else $error("controller commands not one-hot");
	ast_flush_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) && !$past(state_q == S_FLUSH) |->
		$past(state_q == S_STEP) || $past(state_q == S_LOOK) || $past(state_q == S_INFO))
		else $error("flush entered from wrong state");
	ast_idle_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && $past(state_q != S_IDLE) |->
		$past(state_q == S_CLEAR) || $past(state_q == S_FINISH))
		else $error("idle entered mid-scan");

endmodule

// ===== rtl/dlx_dpath.sv =====
// Datapath: DFA tables, lookahead buffer, match registers and result staging.
module dlx_dpath
	import dlx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [ST_W-1:0]  cfg_wdata,
	dlx_in_if.sink           items,
	dlx_out_if.source        results,
	input  dlx_cmd_t         cmd,
	output dlx_sts_t         sts
);

	// memories
	logic [TBL_W-1:0]  tbl_mem  [1<<TBL_AW];
	logic [INFO_W-1:0] info_mem [NUM_STATES];
	logic [7:0]        lbuf_mem [LB_DEPTH];

	logic [TBL_W-1:0]      tbl_rd_q;
	logic [INFO_W-1:0]     info_rd_q;
	logic                  info_hit_q;
	logic [7:0]            lb_rd_q;
	logic [NUM_STATES-1:0] info_vld_q;

	// match and scan registers
	logic [TBL_AW-1:0]     clr_q;
	logic [ST_W-1:0]       start_q, cur_q;
	logic                  acc_q, esc_q, eoi_q, ws_q, last_q;
	logic [TOKEN_BITS-1:0] tok_q;
	logic [LEN_W-1:0]      cpa_q, run_q;
	logic [POS_W-1:0]      pos_q;
	logic [LB_AW-1:0]      base_q, wp_q, hi_q;

	// result staging
	dlx_res_t pend_q, out_q;
	logic     pend_v_q, out_v_q, out_last_q;

	logic             take, take_char, take_trans, take_info;
	logic             last_d, skip_d, femit, out_free, load_out;
	logic [SYM_W-1:0] sym_d;
	logic [LEN_W-1:0] flen;
	logic [LB_AW-1:0] flen_p;
	dlx_res_t         fres;

	// input transfer decode
	always_comb begin
		items.ready = cmd.idle;
		take        = items.valid && cmd.idle;
		take_char   = take && (items.kind == KIND_CHAR);
		take_trans  = take && (items.kind == KIND_TRANS);
		take_info   = take && (items.kind == KIND_INFO);
	end

	// symbol forming from the fetched byte
	always_comb begin
		last_d = eoi_q && ((wp_q + LB_AW'(1)) == hi_q);
		sym_d  = {esc_q, lb_rd_q};
		skip_d = !esc_q && (lb_rd_q == BYTE_BSLASH) && !last_d;
	end

	// flush result
	always_comb begin
		flen            = acc_q ? (run_q - cpa_q) : run_q;
		flen_p          = LB_AW'(flen);
		femit           = acc_q || !ws_q;
		fres.is_error   = !acc_q;
		fres.token_id   = acc_q ? tok_q : '0;
		fres.start_pos  = pos_q;
		fres.lexeme_length = flen;
		out_free        = !out_v_q || results.ready;
		load_out        = pend_v_q && out_free &&
			((cmd.flush && femit) || cmd.finish);
	end

	// status to controller
	always_comb begin
		sts.clear_done = (clr_q == '1);
		sts.start      = take_char;
		sts.caught_up  = (wp_q == hi_q);
		sts.run_full   = (run_q >= LEN_W'(MAX_LEXEME));
		sts.need_look  = !skip_d;
		sts.tbl_hit    = tbl_rd_q[ST_W];
		sts.is_last    = last_q;
		sts.flush_ok   = !(femit && pend_v_q && !out_free);
		sts.finish_ok  = !pend_v_q || out_free;
	end

	// transition table: clearing sweep, loads, one registered read
	always_ff @(posedge clk) begin
		if (cmd.clear) tbl_mem[clr_q] <= '0;
		else if (take_trans)
			tbl_mem[{items.state_index, items.symbol_code}] <=
				items.entry_valid ? {1'b1, items.target_state} : '0;
		tbl_rd_q <= tbl_mem[{cur_q, sym_d}];
	end

	// state info and lookahead buffer
	always_ff @(posedge clk) begin
		if (take_info) info_mem[items.state_index] <= {items.accepting, items.token_code};
		info_rd_q <= info_mem[tbl_rd_q[ST_W-1:0]];
		if (take_char) lbuf_mem[hi_q] <= items.char_byte;
		lb_rd_q <= lbuf_mem[wp_q];
	end

	// payload of staged results
	always_ff @(posedge clk) begin
		if (cmd.flush && sts.flush_ok && femit) pend_q <= fres;
		if (load_out) begin
			out_q      <= pend_q;
			out_last_q <= cmd.finish;
		end
		if (cmd.consume) begin
			last_q <= last_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			info_vld_q <= '0;
			info_hit_q <= 1'b0;
			start_q    <= START_RESET;
			cur_q      <= START_RESET;
			acc_q      <= 1'b0;
			tok_q      <= '0;
			cpa_q      <= '0;
			run_q      <= '0;
			esc_q      <= 1'b0;
			eoi_q      <= 1'b0;
			ws_q       <= 1'b0;
			pos_q      <= '0;
			base_q     <= '0;
			wp_q       <= '0;
			hi_q       <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + TBL_AW'(1);
			if (cfg_we) start_q <= cfg_wdata;
			if (take_info) info_vld_q[items.state_index] <= 1'b1;
			info_hit_q <= info_vld_q[tbl_rd_q[ST_W-1:0]];

			// append a new character
			if (take_char) begin
				hi_q  <= hi_q + LB_AW'(1);
				eoi_q <= items.end_of_input;
			end
			// full run flushes with no failing symbol
			if (cmd.step && !sts.caught_up && sts.run_full) ws_q <= 1'b0;
			// consume one byte
			if (cmd.consume) begin
				run_q <= run_q + LEN_W'(1);
				cpa_q <= cpa_q + LEN_W'(1);
				wp_q  <= wp_q + LB_AW'(1);
				ws_q  <= is_ws(sym_d);
				if (esc_q) esc_q <= 1'b0;
				else if (skip_d) esc_q <= 1'b1;
			end
			// advance the DFA
			if (cmd.look && tbl_rd_q[ST_W]) cur_q <= tbl_rd_q[ST_W-1:0];
			if (cmd.info && info_hit_q && info_rd_q[TOKEN_BITS]) begin
				acc_q <= 1'b1;
				tok_q <= info_rd_q[TOKEN_BITS-1:0];
				cpa_q <= '0;
			end
			// flush: emit, rewind to the accept point, restart the match
			if (cmd.flush && sts.flush_ok) begin
				pos_q  <= pos_q + POS_W'(flen);
				base_q <= base_q + flen_p;
				wp_q   <= base_q + flen_p;
				run_q  <= '0;
				cur_q  <= start_q;
				acc_q  <= 1'b0;
				tok_q  <= '0;
				cpa_q  <= '0;
				esc_q  <= 1'b0;
				if (femit) pend_v_q <= 1'b1;
			end
			if (cmd.finish && out_free) pend_v_q <= 1'b0;
			// output register
			if (load_out) out_v_q <= 1'b1;
			else if (results.ready) out_v_q <= 1'b0;
		end
	end

	// drive result channel
	always_comb begin
		results.valid         = out_v_q;
		results.is_error      = out_q.is_error;
		results.token_id      = out_q.token_id;
		results.start_pos     = out_q.start_pos;
		results.lexeme_length = out_q.lexeme_length;
		results.last          = out_last_q;
	end

	ast_cpa: assert property (@(posedge clk) disable iff (!arst_n) cpa_q <= run_q)
		else $error("lookahead count exceeds run length");
	ast_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= LEN_W'(MAX_LEXEME))
		else $error("run length overflow");
	ast_span: assert property (@(posedge clk) disable iff (!arst_n)
		LB_AW'(hi_q - wp_q) <= LB_AW'(MAX_LEXEME + 1))
		else $error("scan pointer passed fill pointer");
	ast_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idle |-> !pend_v_q && (wp_q == hi_q))
		else $error("idle with unfinished work");

endmodule
